// File: rtl/ibf_pkg.sv
// Shared constants, types and constant tables of the in-place box filter.
`timescale 1ns / 1ps

package ibf_pkg;

   // Frame geometry and window limit
   localparam int FRAME_WIDTH  = 128;
   localparam int FRAME_HEIGHT = 128;
   localparam int MAX_WINDOW   = 15;

   // Field widths
   localparam int PIXEL_W    = 8;
   localparam int CMD_W      = 2;
   localparam int WIN_W      = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 4;

   localparam int PIX_COUNT = FRAME_WIDTH * FRAME_HEIGHT;
   localparam int ADDR_W    = (PIX_COUNT > 1) ? $clog2(PIX_COUNT) : 1;
   localparam int COL_W     = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
   localparam int ROW_W     = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;

   // Effective window side never exceeds what the 4-bit register can hold
   localparam int EFF_MAX  = (MAX_WINDOW < 15) ? MAX_WINDOW : 15;
   localparam int HALF_MAX = EFF_MAX / 2;
   localparam int HALF_W   = (HALF_MAX > 0) ? $clog2(HALF_MAX + 1) : 1;
   localparam int SPAN_W   = HALF_W + 1;
   localparam int SPAN_MAX = 2 * HALF_MAX + 1;

   localparam int DVS_W = (EFF_MAX > 1) ? $clog2(EFF_MAX * EFF_MAX + 1) : 1;
   localparam int SUM_W = $clog2(SPAN_MAX * SPAN_MAX * 255 + 1);

   // Signed unwrapped window coordinates
   localparam int COLU_W = $clog2(FRAME_WIDTH + HALF_MAX + 1) + 1;
   localparam int ROWU_W = $clog2(FRAME_HEIGHT + HALF_MAX + 1) + 1;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD   = 2'd0,
      CMD_FILTER = 2'd1,
      CMD_READ   = 2'd2
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WINDOW_SIZE = 1'b0,
      CSR_BORDER_MODE = 1'b1
   } csr_index_type;

   typedef logic [HALF_MAX:0][COL_W-1:0] col_tab_type;
   typedef logic [HALF_MAX:0][ROW_W-1:0] row_tab_type;

   // Wrapped coordinate of -half for each half width
   function automatic col_tab_type col_wrap_tab();
      col_tab_type t;
      for (int i = 0; i <= HALF_MAX; i++) begin
         t[i] = COL_W'((FRAME_WIDTH - (i % FRAME_WIDTH)) % FRAME_WIDTH);
      end
      return t;
   endfunction

   function automatic row_tab_type row_wrap_tab();
      row_tab_type t;
      for (int i = 0; i <= HALF_MAX; i++) begin
         t[i] = ROW_W'((FRAME_HEIGHT - (i % FRAME_HEIGHT)) % FRAME_HEIGHT);
      end
      return t;
   endfunction

   localparam col_tab_type COL_WRAP_TAB = col_wrap_tab();
   localparam row_tab_type ROW_WRAP_TAB = row_wrap_tab();

   typedef struct packed {
      logic             start;
      logic [SUM_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [SUM_W-1:0] quotient;
   } div_rsp_type;

endpackage

// File: rtl/ibf_if.sv
// Request and response channel interfaces of the in-place box filter.
`timescale 1ns / 1ps

interface ibf_req_if import ibf_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   command;
   logic [PIXEL_W-1:0] pixel_in;

   modport source (output valid, output command, output pixel_in, input ready);
   modport sink (input valid, input command, input pixel_in, output ready);
endinterface

interface ibf_rsp_if import ibf_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel_out;
   logic               frame_end;

   modport source (output valid, output pixel_out, output frame_end, input ready);
   modport sink (input valid, input pixel_out, input frame_end, output ready);
endinterface

// File: rtl/in_place_box_filter.sv
// Top level of the in-place box filter: frame store, window walk and channels.
`timescale 1ns / 1ps

// Holds one FRAME_WIDTH x FRAME_HEIGHT frame of 8-bit pixels in a single
// synchronous memory (one write port, one read port, registered read data).
// req_chan carries commands: load (store pixel_in at the load pointer),
// filter (box filter the whole frame in place, no transaction on rsp_chan)
// and read (return the pixel at the read pointer). Command 3 is taken and
// dropped. rsp_chan returns pixel_out and frame_end for each read.
// csr_we/csr_index/csr_wdata write window_size and border_mode; write them
// only while the block is idle.
// Load and read: one transaction per cycle while no filter pass runs and
// rsp_chan takes results. A read result passes through the memory read
// register and the output register on its way to rsp_chan.
// Filter: for each pixel the sequencer seeds the window walk, issues one
// memory read per window tap over a span x span window, where span is the
// window side (s, or s+1 for even s), drains the read pipe, then waits for
// the bit-serial divider and writes back its quotient. A pass covers every
// pixel of the frame; req_chan is not ready meanwhile.
// Reset clears the pointers, the configuration (window 5, clamp) and the
// control state; the frame store keeps its contents and needs no clearing.
// When rsp_chan stalls, one read result waits in the output register and a
// second in the memory read register; further transactions wait.
module in_place_box_filter import ibf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   ibf_req_if.sink               req_chan,
   ibf_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PIX,
      ST_WALK,
      ST_DRAIN,
      ST_DIV
   } state_type;

   // Frame store
   logic [PIXEL_W-1:0] mem [PIX_COUNT];
   logic [PIXEL_W-1:0] rd_data_ff;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [PIXEL_W-1:0] mem_wdata;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;

   // Configuration
   logic [WIN_W-1:0] window_ff;
   logic             border_ff;

   // Pointers and read path
   logic [ADDR_W-1:0]  load_ptr_ff, read_ptr_ff;
   logic               pend_ff, pend_last_ff;
   logic               pend_move;
   logic               rsp_valid_ff, rsp_end_ff;
   logic [PIXEL_W-1:0] rsp_pixel_ff;

   // Handshake
   logic req_ready, req_acc;
   logic load_acc, read_acc, filter_acc;

   // Filter pass
   state_type                 state_ff, state_in;
   logic [HALF_W-1:0]         half_ff, half_in;
   logic [DVS_W-1:0]          divisor_ff, divisor_in;
   logic [ROW_W-1:0]          pix_row_ff, pix_row_in;
   logic [COL_W-1:0]          pix_col_ff, pix_col_in;
   logic [ADDR_W-1:0]         pix_addr_ff, pix_addr_in;
   logic [ROW_W-1:0]          rstart_ff, rstart_in;
   logic [COL_W-1:0]          cstart_ff, cstart_in;
   logic [SPAN_W-1:0]         dr_ff, dr_in, dc_ff, dc_in;
   logic signed [ROWU_W-1:0]  row_u_ff, row_u_in;
   logic signed [COLU_W-1:0]  col_u_ff, col_u_in;
   logic [ROW_W-1:0]          row_w_ff, row_w_in;
   logic [COL_W-1:0]          col_w_ff, col_w_in;
   logic                      acc_en_ff;
   logic [SUM_W-1:0]          sum_ff, sum_next;

   logic [WIN_W-1:0]   s_eff;
   logic [2*WIN_W-1:0] s_sq;
   logic [HALF_W-1:0]  half_new;
   logic [SPAN_W-1:0]  span_last;
   logic [ROW_W-1:0]   row_sel;
   logic [COL_W-1:0]   col_sel;
   logic [ADDR_W-1:0]  walk_addr;
   logic signed [COLU_W-1:0] col_first;
   logic               walk_issue;
   logic               last_pix;

   div_req_type div_req;
   div_rsp_type div_rsp;

   function automatic logic [COL_W-1:0] col_inc(input logic [COL_W-1:0] x);
      return (x == COL_W'(FRAME_WIDTH - 1)) ? '0 : x + 1'b1;
   endfunction

   function automatic logic [ROW_W-1:0] row_inc(input logic [ROW_W-1:0] x);
      return (x == ROW_W'(FRAME_HEIGHT - 1)) ? '0 : x + 1'b1;
   endfunction

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WIN_W'(5);
         border_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WINDOW_SIZE: window_ff <= csr_wdata[WIN_W-1:0];
            CSR_BORDER_MODE: border_ff <= csr_wdata[0];
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Request decode: take a transaction only when idle and the read path
   // has room for a result.
   // ---------------------------------------------------------------------
   assign pend_move = pend_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_ready = (state_ff == ST_IDLE) && (!pend_ff || pend_move);
   assign req_acc   = req_chan.valid && req_ready;
   assign req_chan.ready = req_ready;

   always_comb begin
      load_acc   = 1'b0;
      read_acc   = 1'b0;
      filter_acc = 1'b0;
      unique case (req_chan.command)
         CMD_LOAD:   load_acc   = req_acc;
         CMD_FILTER: filter_acc = req_acc;
         CMD_READ:   read_acc   = req_acc;
         default:    ;
      endcase
   end

   // ---------------------------------------------------------------------
   // Pointers and read result path
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         load_ptr_ff  <= '0;
         read_ptr_ff  <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load_acc) begin
            load_ptr_ff <= (load_ptr_ff == ADDR_W'(PIX_COUNT - 1)) ?
                           '0 : load_ptr_ff + 1'b1;
         end
         if (read_acc) begin
            read_ptr_ff <= (read_ptr_ff == ADDR_W'(PIX_COUNT - 1)) ?
                           '0 : read_ptr_ff + 1'b1;
         end
         // hold the memory read data until the output register frees up
         if (read_acc) begin
            pend_ff <= 1'b1;
         end else if (pend_move) begin
            pend_ff <= 1'b0;
         end
         if (pend_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (read_acc) begin
         pend_last_ff <= (read_ptr_ff == ADDR_W'(PIX_COUNT - 1));
      end
      if (pend_move) begin
         rsp_pixel_ff <= rd_data_ff;
         rsp_end_ff   <= pend_last_ff;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.pixel_out = rsp_pixel_ff;
   assign rsp_chan.frame_end = rsp_end_ff;

   // ---------------------------------------------------------------------
   // Window walk address: clamp or wrap each coordinate.
   // ---------------------------------------------------------------------
   always_comb begin
      if (border_ff) begin
         row_sel = row_w_ff;
         col_sel = col_w_ff;
      end else begin
         if (row_u_ff < 0) begin
            row_sel = '0;
         end else if (row_u_ff > $signed(ROWU_W'(FRAME_HEIGHT - 1))) begin
            row_sel = ROW_W'(FRAME_HEIGHT - 1);
         end else begin
            row_sel = row_u_ff[ROW_W-1:0];
         end
         if (col_u_ff < 0) begin
            col_sel = '0;
         end else if (col_u_ff > $signed(COLU_W'(FRAME_WIDTH - 1))) begin
            col_sel = COL_W'(FRAME_WIDTH - 1);
         end else begin
            col_sel = col_u_ff[COL_W-1:0];
         end
      end
   end

   assign walk_addr  = ADDR_W'(row_sel * FRAME_WIDTH) + ADDR_W'(col_sel);
   assign walk_issue = (state_ff == ST_WALK);
   assign span_last  = {half_ff, 1'b0};
   assign col_first  = $signed(COLU_W'(pix_col_ff)) - $signed(COLU_W'(half_ff));
   assign last_pix   = (pix_addr_ff == ADDR_W'(PIX_COUNT - 1));

   // window side: zero acts as one, saturate at the maximum
   always_comb begin
      if (window_ff == '0) begin
         s_eff = WIN_W'(1);
      end else if (32'(window_ff) > EFF_MAX) begin
         s_eff = WIN_W'(EFF_MAX);
      end else begin
         s_eff = window_ff;
      end
   end
   assign s_sq     = {{WIN_W{1'b0}}, s_eff} * {{WIN_W{1'b0}}, s_eff};
   assign half_new = HALF_W'(s_eff >> 1);

   // ---------------------------------------------------------------------
   // Frame store
   // ---------------------------------------------------------------------
   assign rd_en     = read_acc || walk_issue;
   assign rd_addr   = walk_issue ? walk_addr : read_ptr_ff;
   assign mem_we    = load_acc || ((state_ff == ST_DIV) && div_rsp.done);
   assign mem_waddr = load_acc ? load_ptr_ff : pix_addr_ff;
   assign mem_wdata = load_acc ? req_chan.pixel_in : div_rsp.quotient[PIXEL_W-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // ---------------------------------------------------------------------
   // Accumulate window taps in the cycle after their reads
   // ---------------------------------------------------------------------
   assign sum_next = sum_ff + SUM_W'(rd_data_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_en_ff <= 1'b0;
      end else begin
         acc_en_ff <= walk_issue;
      end
      if (state_ff == ST_PIX) begin
         sum_ff <= '0;
      end else if (acc_en_ff) begin
         sum_ff <= sum_next;
      end
   end

   // last tap arrives during the drain cycle; feed it straight in
   assign div_req.start    = (state_ff == ST_DRAIN);
   assign div_req.dividend = sum_next;
   assign div_req.divisor  = divisor_ff;

   ibf_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // ---------------------------------------------------------------------
   // Filter pass sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in    = state_ff;
      half_in     = half_ff;
      divisor_in  = divisor_ff;
      pix_row_in  = pix_row_ff;
      pix_col_in  = pix_col_ff;
      pix_addr_in = pix_addr_ff;
      rstart_in   = rstart_ff;
      cstart_in   = cstart_ff;
      dr_in       = dr_ff;
      dc_in       = dc_ff;
      row_u_in    = row_u_ff;
      col_u_in    = col_u_ff;
      row_w_in    = row_w_ff;
      col_w_in    = col_w_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (filter_acc) begin
               half_in     = half_new;
               divisor_in  = DVS_W'(s_sq);
               pix_row_in  = '0;
               pix_col_in  = '0;
               pix_addr_in = '0;
               rstart_in   = ROW_WRAP_TAB[half_new];
               cstart_in   = COL_WRAP_TAB[half_new];
               state_in    = ST_PIX;
            end
         end
         ST_PIX: begin
            // seed the window at the top left tap
            dr_in    = '0;
            dc_in    = '0;
            row_u_in = $signed(ROWU_W'(pix_row_ff)) - $signed(ROWU_W'(half_ff));
            col_u_in = col_first;
            row_w_in = rstart_ff;
            col_w_in = cstart_ff;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (dc_ff == span_last) begin
               dc_in    = '0;
               col_u_in = col_first;
               col_w_in = cstart_ff;
               dr_in    = dr_ff + 1'b1;
               row_u_in = row_u_ff + 1'b1;
               row_w_in = row_inc(row_w_ff);
               if (dr_ff == span_last) begin
                  state_in = ST_DRAIN;
               end
            end else begin
               dc_in    = dc_ff + 1'b1;
               col_u_in = col_u_ff + 1'b1;
               col_w_in = col_inc(col_w_ff);
            end
         end
         ST_DRAIN: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // write back happens on done; advance to the next pixel, or return to idle after the last
            if (div_rsp.done) begin
               if (last_pix) begin
                  state_in = ST_IDLE;
               end else begin
                  pix_addr_in = pix_addr_ff + 1'b1;
                  if (pix_col_ff == COL_W'(FRAME_WIDTH - 1)) begin
                     pix_col_in = '0;
                     pix_row_in = pix_row_ff + 1'b1;
                     cstart_in  = COL_WRAP_TAB[half_ff];
                     rstart_in  = row_inc(rstart_ff);
                  end else begin
                     pix_col_in = pix_col_ff + 1'b1;
                     cstart_in  = col_inc(cstart_ff);
                  end
                  state_in = ST_PIX;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      half_ff     <= half_in;
      divisor_ff  <= divisor_in;
      pix_row_ff  <= pix_row_in;
      pix_col_ff  <= pix_col_in;
      pix_addr_ff <= pix_addr_in;
      rstart_ff   <= rstart_in;
      cstart_ff   <= cstart_in;
      dr_ff       <= dr_in;
      dc_ff       <= dc_in;
      row_u_ff    <= row_u_in;
      col_u_ff    <= col_u_in;
      row_w_ff    <= row_w_in;
      col_w_ff    <= col_w_in;
   end

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // a filter pass reuses the read register, so no read result may wait
   a_no_pend_in_pass: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !pend_ff)
      else $error("read result pending during filter pass");

   // taps are summed only in the cycle after a walk read
   a_acc_after_walk: assert property (@(posedge clock) disable iff (reset)
      acc_en_ff |-> $past(state_ff == ST_WALK))
      else $error("accumulate without a window read");

   // divider completes only while the sequencer waits for it
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIV))
      else $error("divider done outside divide state");

   // a stalled read result keeps its data in the read register
   a_pend_hold: assert property (@(posedge clock) disable iff (reset)
      (pend_ff && !pend_move) |=> (pend_ff && $stable(rd_data_ff)))
      else $error("pending read result lost");

endmodule

// File: rtl/ibf_div.sv
// Restoring divider: one quotient bit per cycle for the window mean.
`timescale 1ns / 1ps

module ibf_div import ibf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   localparam int CNT_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [SUM_W-1:0] quo_ff, quo_in;
   logic [DVS_W:0]   trial;
   logic             fits;

   assign trial = {rem_ff, quo_ff[SUM_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvs_in  = req.divisor;
         quo_in  = req.dividend;
      end else if (busy_ff) begin
         // shift in one quotient bit, keep the partial remainder
         rem_in = fits ? DVS_W'(trial - {1'b0, dvs_ff}) : trial[DVS_W-1:0];
         quo_in = {quo_ff[SUM_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule
